// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/dtfs_pkg.sv -----
// shared types and constants of the depth table floor search block
// no dependencies
`default_nettype none
package dtfs_pkg;
   localparam int DEFAULT_TABLE_DEPTH  = 2048;
   localparam int DEFAULT_MAX_INDEX    = 1092;
   localparam int DEFAULT_SEARCH_START = 546;
   localparam int DEFAULT_FIRST_STEP   = 273;

   localparam int ENTRY_W       = 32;
   localparam int INDEX_FIELD_W = 11;
   localparam int EXT_W         = 13;
   localparam int REQ_TDATA_W   = 80;
   localparam int RSP_TDATA_W   = 16;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DOWN,
      ST_UP,
      ST_FINISH
   } state_type;

   // request to the shared index unit
   typedef struct packed {
      logic sub;
      logic by_step;
   } step_req_type;

   // entry compared against the query depth
   typedef struct packed {
      logic gt;
      logic lt;
      logic eq;
   } cmp_flags_type;
endpackage
`default_nettype wire

// ----- rtl/dtfs_ram.sv -----
// generic single port write, single port read ram with registered read
// no dependencies
`default_nettype none
module dtfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/dtfs_step_unit.sv -----
// shared compare and index step unit: compares an entry with the query and
// moves an index up or down by the step or by one, clamped to the table
// depends on dtfs_pkg
`default_nettype none
module dtfs_step_unit #(
   parameter int TABLE_DEPTH = dtfs_pkg::DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = 11,
   parameter int STEP_W      = 9
) (
   input  wire logic signed [dtfs_pkg::ENTRY_W-1:0] entry,
   input  wire logic signed [dtfs_pkg::ENTRY_W-1:0] query,
   input  wire logic        [IDX_W-1:0]             base,
   input  wire logic        [STEP_W-1:0]            step,
   input  wire dtfs_pkg::step_req_type              req,
   output dtfs_pkg::cmp_flags_type                  flags,
   output logic             [IDX_W-1:0]             result
);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [SUM_W-1:0] LAST = SUM_W'(TABLE_DEPTH - 1);

   logic [SUM_W-1:0] base_ext;
   logic [SUM_W-1:0] delta;
   logic [SUM_W-1:0] sum;

   always_comb begin
      flags.gt = entry > query;
      flags.lt = entry < query;
      flags.eq = entry == query;
   end

   always_comb begin
      base_ext = SUM_W'(base);
      delta    = req.by_step ? SUM_W'(step) : SUM_W'(1);
      sum      = base_ext + delta;
      if (req.sub) begin
         // saturate at index zero
         result = (delta > base_ext) ? '0 : IDX_W'(base_ext - delta);
      end else begin
         result = (sum > LAST) ? IDX_W'(LAST) : IDX_W'(sum);
      end
   end
endmodule
`default_nettype wire

// ----- rtl/depth_table_floor_search.sv -----
// depth table floor search: a write item stores one table entry, a query item
// returns the index whose entry is the floor of its depth
// both items are taken only in idle; a query then runs the binary search steps, walks down
// while the entry is above the depth, probes upward, and ends in a finish step that waits on
// a pending result before it raises rsp_tvalid; sync reset clears control only, table undefined
`default_nettype none
`include "assert_macros.svh"
module depth_table_floor_search #(
   parameter int TABLE_DEPTH  = dtfs_pkg::DEFAULT_TABLE_DEPTH,
   parameter int MAX_INDEX    = dtfs_pkg::DEFAULT_MAX_INDEX,
   parameter int SEARCH_START = dtfs_pkg::DEFAULT_SEARCH_START,
   parameter int FIRST_STEP   = dtfs_pkg::DEFAULT_FIRST_STEP
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // entry_index [10:0], entry_value [42:11], query_depth [74:43], zero fill
   input  wire logic [dtfs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func [0]
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // found_index [10:0], zero fill
   output logic      [dtfs_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int STEP_W  = $clog2(FIRST_STEP + 1);
   localparam int EXT_W   = dtfs_pkg::EXT_W;
   localparam int START_I = (SEARCH_START > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : SEARCH_START;
   localparam logic [IDX_W-1:0]  START_IDX = IDX_W'(START_I);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [EXT_W-1:0]  MAX_EXT   = EXT_W'(MAX_INDEX);
   localparam logic [EXT_W-1:0]  DEPTH_EXT = EXT_W'(TABLE_DEPTH);

   logic [dtfs_pkg::INDEX_FIELD_W-1:0] entry_index;
   logic signed [dtfs_pkg::ENTRY_W-1:0] entry_value;
   logic signed [dtfs_pkg::ENTRY_W-1:0] query_depth;
   dtfs_pkg::func_type func;

   assign entry_index = req_tdata[10:0];
   assign entry_value = req_tdata[42:11];
   assign query_depth = req_tdata[74:43];
   assign func        = dtfs_pkg::func_type'(req_tuser);

   dtfs_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  probe_ff, probe_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic signed [dtfs_pkg::ENTRY_W-1:0] query_ff, query_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [dtfs_pkg::INDEX_FIELD_W-1:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic [EXT_W-1:0] entry_ext;
   logic [EXT_W-1:0] idx_ext;
   logic [EXT_W-1:0] probe_ext;
   logic wr_en;
   logic rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic signed [dtfs_pkg::ENTRY_W-1:0] rd_data;

   dtfs_pkg::step_req_type  step_req;
   dtfs_pkg::cmp_flags_type flags;
   logic [IDX_W-1:0] unit_base;
   logic [IDX_W-1:0] unit_result;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == dtfs_pkg::ST_IDLE);
   assign entry_ext  = EXT_W'(entry_index);
   assign idx_ext    = EXT_W'(idx_ff);
   assign probe_ext  = EXT_W'(probe_ff);
   // writes past the table end are dropped
   assign wr_en = accept && (func == dtfs_pkg::FUNC_WRITE) && (entry_ext < DEPTH_EXT);

   dtfs_ram #(
      .WIDTH (dtfs_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_ext[IDX_W-1:0]),
      .wr_data (entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dtfs_step_unit #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .STEP_W      (STEP_W)
   ) u_step (
      .entry  (rd_data),
      .query  (query_ff),
      .base   (unit_base),
      .step   (step_ff),
      .req    (step_req),
      .flags  (flags),
      .result (unit_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtfs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      probe_ff    <= probe_in;
      step_ff     <= step_in;
      query_ff    <= query_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      step_in      = step_ff;
      query_in     = query_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      unit_base    = idx_ff;
      step_req     = '{sub: 1'b0, by_step: 1'b0};

      case (state_ff)
         dtfs_pkg::ST_IDLE: begin
            if (accept && (func == dtfs_pkg::FUNC_QUERY)) begin
               query_in = query_depth;
               idx_in   = START_IDX;
               step_in  = STEP_W'(FIRST_STEP);
               rd_en    = 1'b1;
               rd_addr  = START_IDX;
               state_in = dtfs_pkg::ST_SEARCH;
            end
         end
         dtfs_pkg::ST_SEARCH: begin
            // rd_data holds table[idx_ff]
            rd_en    = 1'b1;
            step_req = '{sub: flags.gt, by_step: 1'b1};
            if (flags.eq) begin
               rd_addr  = idx_ff;
               state_in = dtfs_pkg::ST_DOWN;
            end else begin
               idx_in  = unit_result;
               rd_addr = unit_result;
               step_in = step_ff >> 1;
               if (step_in == '0) begin
                  state_in = dtfs_pkg::ST_DOWN;
               end
            end
         end
         dtfs_pkg::ST_DOWN: begin
            // walk down while the entry is above the depth
            if (idx_ff != '0 && flags.gt) begin
               step_req = '{sub: 1'b1, by_step: 1'b0};
               idx_in   = unit_result;
               rd_en    = 1'b1;
               rd_addr  = unit_result;
            end else if (idx_ff != LAST_IDX && idx_ext <= MAX_EXT) begin
               step_req = '{sub: 1'b0, by_step: 1'b0};
               probe_in = unit_result;
               rd_en    = 1'b1;
               rd_addr  = unit_result;
               state_in = dtfs_pkg::ST_UP;
            end else begin
               state_in = dtfs_pkg::ST_FINISH;
            end
         end
         dtfs_pkg::ST_UP: begin
            // rd_data holds table[probe_ff], probe_ff is idx_ff plus one
            unit_base = probe_ff;
            step_req  = '{sub: 1'b0, by_step: 1'b0};
            if (flags.lt) begin
               idx_in = probe_ff;
               if (probe_ff != LAST_IDX && probe_ext <= MAX_EXT) begin
                  probe_in = unit_result;
                  rd_en    = 1'b1;
                  rd_addr  = unit_result;
               end else begin
                  state_in = dtfs_pkg::ST_FINISH;
               end
            end else begin
               state_in = dtfs_pkg::ST_FINISH;
            end
         end
         dtfs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = idx_ext[dtfs_pkg::INDEX_FIELD_W-1:0];
               state_in     = dtfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtfs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dtfs_pkg::RSP_TDATA_W - dtfs_pkg::INDEX_FIELD_W){1'b0}}, rsp_data_ff};

   `ASSERT_IMPL(a_search_step_nonzero, clock, reset, state_ff == dtfs_pkg::ST_SEARCH,
                step_ff != '0, "search step reached zero inside the search")
   `ASSERT_IMPL(a_probe_follows_idx, clock, reset, state_ff == dtfs_pkg::ST_UP,
                probe_ff == IDX_W'(idx_ff + 1'b1), "upward probe is not next to the index")
   `ASSERT_IMPL(a_up_within_max, clock, reset, state_ff == dtfs_pkg::ST_UP,
                idx_ext <= MAX_EXT, "upward walk passed the maximum index")
   `ASSERT_IMPL(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff),
                $past(state_ff) == dtfs_pkg::ST_FINISH, "result raised outside the finish step")
   `ASSERT_IMPL(a_write_only_idle, clock, reset, wr_en,
                state_ff == dtfs_pkg::ST_IDLE && !rd_en, "table write collides with a search read")
endmodule
`default_nettype wire

// ----- sim/depth_table_floor_search_tb.sv -----
// self-checking testbench for depth_table_floor_search: loads the depth table, then
// streams directed and random writes and queries with random stalls on both sides
// depends on dtfs_pkg and the depth_table_floor_search rtl
module depth_table_floor_search_tb;
   import dtfs_pkg::*;

   localparam int READ_SPAN    = DEFAULT_MAX_INDEX + 2;  // entries 0..1093 can be read
   localparam int RANDOM_ITEMS = 730;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int TAIL_CYCLES  = 40;
   localparam int DEPTH_MIN    = -2147483647 - 1;
   localparam int DEPTH_MAX    = 2147483647;

   typedef struct {
      func_type                 func;
      logic [INDEX_FIELD_W-1:0] entry_index;
      logic [ENTRY_W-1:0]       entry_value;
      logic [ENTRY_W-1:0]       query_depth;
      bit                       wait_drain;
   } lookup_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   lookup_item_type            pending_items [$];
   lookup_item_type            item_on_bus;
   logic [INDEX_FIELD_W-1:0]   expected_index_q [$];
   int                         floor_table [DEFAULT_TABLE_DEPTH];  // predictor copy
   int                         plan_table  [DEFAULT_TABLE_DEPTH];  // stimulus shadow
   int                         cycle_count = 0;
   int                         fail_count = 0;
   int                         writes_accepted = 0;
   int                         queries_accepted = 0;
   int                         results_checked = 0;
   bit                         calm;

   depth_table_floor_search u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // no idling on either side over one stretch of the run
   assign calm = (writes_accepted + queries_accepted >= 1300) &&
                 (writes_accepted + queries_accepted < 1500);

   function automatic int saturate_index(input int idx);
      if (idx < 0) begin
         return 0;
      end
      if (idx > DEFAULT_TABLE_DEPTH - 1) begin
         return DEFAULT_TABLE_DEPTH - 1;
      end
      return idx;
   endfunction

   // binary search from the fixed start, then fix-up walks down and up
   function automatic logic [INDEX_FIELD_W-1:0] floor_index(input int depth);
      int idx;
      int stride;
      idx = saturate_index(DEFAULT_SEARCH_START);
      stride = DEFAULT_FIRST_STEP;
      while (stride > 0 && floor_table[idx] != depth) begin
         if (floor_table[idx] > depth) begin
            idx = saturate_index(idx - stride);
         end else begin
            idx = saturate_index(idx + stride);
         end
         stride = stride >>> 1;
      end
      while (idx > 0 && floor_table[idx] > depth) begin
         idx--;
      end
      while (idx + 1 < DEFAULT_TABLE_DEPTH && idx <= DEFAULT_MAX_INDEX &&
             floor_table[idx + 1] < depth) begin
         idx++;
      end
      return idx[INDEX_FIELD_W-1:0];
   endfunction

   // driver
   always @(posedge clock) begin
      bit present;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            if (item_on_bus.func == FUNC_WRITE) begin
               floor_table[item_on_bus.entry_index] = int'(item_on_bus.entry_value);
               writes_accepted++;
            end else begin
               expected_index_q.push_back(floor_index(int'(item_on_bus.query_depth)));
               queries_accepted++;
            end
         end
         present = 1'b0;
         if (pending_items.size() > 0 &&
             !(pending_items[0].wait_drain && expected_index_q.size() > 0) &&
             (calm || $urandom_range(99) >= 26)) begin
            item_on_bus = pending_items.pop_front();
            req_tdata <= {{(REQ_TDATA_W - 75){1'b0}}, item_on_bus.query_depth,
                          item_on_bus.entry_value, item_on_bus.entry_index};
            req_tuser <= item_on_bus.func;
            present = 1'b1;
         end
         req_tvalid <= present;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      logic [INDEX_FIELD_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_index_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected result: found_index %0d", rsp_tdata[INDEX_FIELD_W-1:0]);
               end
            end else begin
               want = expected_index_q.pop_front();
               results_checked++;
               if (rsp_tdata[INDEX_FIELD_W-1:0] !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("found_index mismatch: expected %0d, got %0d", want,
                              rsp_tdata[INDEX_FIELD_W-1:0]);
                  end
               end
            end
         end
         rsp_tready <= calm || $urandom_range(99) >= 26;
      end
   end

   task automatic add_write(input int idx, input int value, input bit drain = 1'b0);
      lookup_item_type it;
      it.func        = FUNC_WRITE;
      it.entry_index = idx[INDEX_FIELD_W-1:0];
      it.entry_value = value;
      it.query_depth = $urandom;
      it.wait_drain  = drain;
      plan_table[idx] = value;
      pending_items.push_back(it);
   endtask

   task automatic add_query(input int depth, input bit drain = 1'b0);
      lookup_item_type it;
      it.func        = FUNC_QUERY;
      it.entry_index = $urandom;
      it.entry_value = $urandom;
      it.query_depth = depth;
      it.wait_drain  = drain;
      pending_items.push_back(it);
   endtask

   function automatic int pick_between(input longint lo, input longint hi);
      longint unsigned r;
      if (hi <= lo) begin
         return int'(lo);
      end
      r = {$urandom, $urandom};
      return int'(lo + longint'(r % longint'(hi - lo + 1)));
   endfunction

   function automatic int nudge(input int value, input int offset);
      longint v;
      v = longint'(value) + offset;
      if (v < DEPTH_MIN) begin
         v = DEPTH_MIN;
      end
      if (v > DEPTH_MAX) begin
         v = DEPTH_MAX;
      end
      return int'(v);
   endfunction

   initial begin
      longint level;
      int     made;
      int     sel;
      int     kind;
      int     idx;
      int     run_len;
      bit     drain;

      // nondecreasing table over the full depth range, with flat runs
      level = DEPTH_MIN;
      for (int i = 0; i < READ_SPAN; i++) begin
         if (i > 0 && $urandom_range(99) >= 20) begin
            level += $urandom_range(7800000);
         end
         if (level > DEPTH_MAX || i == READ_SPAN - 1) begin
            level = DEPTH_MAX;
         end
         add_write(i, int'(level));
      end

      // directed: a write at the last index beyond the searched range, a write of the lowest
      // depth at index 1024, depth extremes, immediate match at the start point, walks stopping at both ends
      add_write(DEFAULT_TABLE_DEPTH - 1, DEPTH_MAX);
      add_write(1024, DEPTH_MIN);
      add_query(DEPTH_MIN);
      add_query(DEPTH_MAX);
      add_query(0);
      add_query(-1);
      add_query(plan_table[DEFAULT_SEARCH_START]);
      add_query(plan_table[0]);
      add_query(plan_table[READ_SPAN - 1]);
      add_query(plan_table[DEFAULT_MAX_INDEX]);
      add_query(nudge(plan_table[DEFAULT_MAX_INDEX], 1));
      add_query(pick_between(plan_table[700], plan_table[701]));
      add_query(nudge(plan_table[300], -1));
      add_query(nudge(plan_table[300], 1));
      add_write(0, DEPTH_MIN + 1000);
      add_query(DEPTH_MIN);
      add_query(DEPTH_MIN + 1000);
      add_write(READ_SPAN - 1, plan_table[DEFAULT_MAX_INDEX]);
      add_query(DEPTH_MAX);
      add_query(plan_table[DEFAULT_MAX_INDEX]);

      // random: mostly queries against a table kept in order, some noise writes
      made = 0;
      while (made < RANDOM_ITEMS) begin
         drain = (made == 0) || (made == RANDOM_ITEMS / 2);
         sel = $urandom_range(99);
         idx = $urandom_range(READ_SPAN - 1);
         if (sel < 65) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
               add_query(plan_table[idx], drain);
            end else if (kind < 55) begin
               add_query(nudge(plan_table[idx], int'($urandom_range(4)) - 2), drain);
            end else if (kind < 75 && idx < READ_SPAN - 1) begin
               add_query(pick_between(plan_table[idx], plan_table[idx + 1]), drain);
            end else if (kind < 92) begin
               add_query($urandom, drain);
            end else begin
               case ($urandom_range(3))
                  0: add_query(DEPTH_MIN, drain);
                  1: add_query(DEPTH_MAX, drain);
                  2: add_query(nudge(plan_table[0], -1), drain);
                  default: add_query(nudge(plan_table[READ_SPAN - 1], 1), drain);
               endcase
            end
            made++;
         end else if (sel < 85) begin
            // keeps the table in order between its neighbors
            add_write(idx, pick_between(idx > 0 ? plan_table[idx - 1] : DEPTH_MIN,
                                        idx < READ_SPAN - 1 ? plan_table[idx + 1] : DEPTH_MAX),
                      drain);
            made++;
         end else if (sel < 91) begin
            // flat run of equal entries
            run_len = $urandom_range(24, 3);
            for (int k = 0; k < run_len && idx + k < READ_SPAN; k++) begin
               add_write(idx + k, plan_table[idx], drain && k == 0);
               made++;
            end
         end else if (sel < 97) begin
            add_write($urandom_range(DEFAULT_TABLE_DEPTH - 1, READ_SPAN), $urandom, drain);
            made++;
         end else begin
            // out-of-order entry
            add_write(idx, $urandom, drain);
            made++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() > 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (expected_index_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("table writes: %0d, depth queries: %0d, results checked: %0d",
               writes_accepted, queries_accepted, results_checked);
      $display("covered exact hits, depths between and outside entries, flat runs, noise");
      if (fail_count == 0 && expected_index_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("mismatches: %0d", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/dtfs_pkg.sv
rtl/dtfs_ram.sv
rtl/dtfs_step_unit.sv
rtl/depth_table_floor_search.sv
sim/depth_table_floor_search_tb.sv
